@@ hdl/scfd_pkg.sv @@
// shared types, constants and the crc byte update for the sensor frame checker
`timescale 1ns / 1ps

package scfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned WORD_W   = 16;

    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

    // byte positions inside a reply frame
    localparam logic [POS_W-1:0] POS_FIRST   = 3'd0;
    localparam logic [POS_W-1:0] POS_HUM_HI  = 3'd2;
    localparam logic [POS_W-1:0] POS_HUM_LO  = 3'd3;
    localparam logic [POS_W-1:0] POS_TEMP_HI = 3'd4;
    localparam logic [POS_W-1:0] POS_TEMP_LO = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 3'd6;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 3'd7;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // classified byte as it travels through the queue
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
    } t_item;

    typedef struct packed {
        logic                     status;
        logic [WORD_W-1:0]        humidity;
        logic signed [WORD_W-1:0] temperature;
    } t_result;

    // crc-16/modbus, lsb first, eight shift steps per byte
    function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] crc;
        logic              lsb;
        crc = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            lsb = crc[0];
            crc = {1'b0, crc[WORD_W-1:1]};
            if (lsb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

@@ hdl/sensor_frame_crc_decoder_unit.sv @@
// top level of the sensor reply frame checker
//
// usage: reply bytes enter on the s_axis stream, one word per byte, byte 0
// to byte 7 of a frame in order; s_axis_tuser set marks byte 0 and
// resynchronizes the frame, otherwise positions simply count on and wrap.
// after byte 7 one result word leaves on m_axis: tuser carries the status
// (0 crc good, 1 crc bad), tdata the humidity and the signed temperature in
// tenths, both zero on a bad crc.
// throughput: one byte per cycle sustained while the queue has room; the front
// end tags the position, a queue of QUEUE_DEPTH entries sits before the back
// end, whose crc update takes in a whole byte at each step.
// with the queue empty, byte 7 passes the queue write and then the back end
// step into the output register before the result shows as valid.
// reset clears the frame position, the queue, the crc register and the
// output valid. when the receiver stalls the result holds in the output
// register; bytes keep flowing until a closing byte waits for it, then the
// queue fills and s_axis_tready drops.
`timescale 1ns / 1ps

module sensor_frame_crc_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths
    output logic        m_axis_tuser    // [0] status
);

    logic              w_push;
    logic              w_full;
    logic              w_q_valid;
    logic              w_pop;
    scfd_pkg::t_item   w_in_item;
    scfd_pkg::t_item   w_q_item;
    scfd_pkg::t_result w_result;

    scfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .o_push        (w_push),
        .o_item        (w_in_item),
        .i_full        (w_full)
    );

    scfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    scfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_pop    (w_pop),
        .i_item   (w_q_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tuser = w_result.status;
    assign m_axis_tdata = {w_result.temperature, w_result.humidity};

    // a bad frame never shows readings
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == scfd_pkg::STATUS_BAD) |-> (m_axis_tdata == '0))
        else $error("bad crc result carries nonzero readings");

    // the input side only backs off when the queue is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_full)
        else $error("input stalled with room in the queue");

    // a closing byte leaves the queue only when the output register is free
    a_last_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && w_pop && w_q_item.pos == scfd_pkg::POS_CRC_HI)
            |-> (!m_axis_tvalid || m_axis_tready))
        else $error("closing byte consumed while result still pending");

    // a new result only follows a consumed closing byte
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |->
            $past(w_q_valid && w_pop && w_q_item.pos == scfd_pkg::POS_CRC_HI))
        else $error("result appeared without a closing byte");

endmodule

@@ hdl/scfd_front.sv @@
// front end: accepts reply bytes and tags each with its frame position
`timescale 1ns / 1ps

module scfd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [scfd_pkg::BYTE_W-1:0] i_data,
    input  logic                        i_frame_start,
    output logic                        o_push,
    output scfd_pkg::t_item             o_item,
    input  logic                        i_full
);

    logic [scfd_pkg::POS_W-1:0] r_pos;
    logic [scfd_pkg::POS_W-1:0] n_pos;
    logic [scfd_pkg::POS_W-1:0] w_pos;

    // start flag forces the byte to position zero
    assign w_pos   = i_frame_start ? scfd_pkg::POS_FIRST : r_pos;
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_item  = '{data: i_data, pos: w_pos};
    assign n_pos   = w_pos + scfd_pkg::POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= scfd_pkg::POS_FIRST;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

endmodule

@@ hdl/scfd_fifo.sv @@
// short queue between the front end and the back end
`timescale 1ns / 1ps

module scfd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  scfd_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output scfd_pkg::t_item o_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    scfd_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ hdl/scfd_back.sv @@
// back end: crc update, word capture, frame check and output register
`timescale 1ns / 1ps

module scfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_pop,
    input  scfd_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output scfd_pkg::t_result o_result
);

    logic [scfd_pkg::WORD_W-1:0] r_crc;
    logic [scfd_pkg::WORD_W-1:0] n_crc;
    logic [scfd_pkg::WORD_W-1:0] w_crc_base;
    logic [scfd_pkg::WORD_W-1:0] r_humidity;
    logic [scfd_pkg::WORD_W-1:0] r_temperature;
    logic [scfd_pkg::BYTE_W-1:0] r_crc_low;
    logic                        r_out_valid;
    scfd_pkg::t_result           r_result;
    scfd_pkg::t_result           n_result;
    logic                        w_is_last;
    logic                        w_fire;
    logic                        w_out_free;
    logic [scfd_pkg::WORD_W-1:0] w_received;
    logic [scfd_pkg::WORD_W-1:0] w_magnitude;

    assign w_is_last  = (i_item.pos == scfd_pkg::POS_CRC_HI);
    assign w_out_free = !r_out_valid || i_ready;
    // only the closing byte needs room in the output register
    assign o_pop      = !w_is_last || w_out_free;
    assign w_fire     = i_valid && o_pop;

    assign w_crc_base  = (i_item.pos == scfd_pkg::POS_FIRST) ? scfd_pkg::CRC_INIT : r_crc;
    assign w_received  = {i_item.data, r_crc_low};
    assign w_magnitude = {1'b0, r_temperature[scfd_pkg::WORD_W-2:0]};

    always_comb begin
        n_crc = r_crc;
        if (i_item.pos < scfd_pkg::POS_CRC_LO) begin
            n_crc = scfd_pkg::crc_feed(w_crc_base, i_item.data);
        end else if (w_is_last) begin
            n_crc = scfd_pkg::CRC_INIT;
        end
    end

    always_comb begin
        if (w_received == r_crc) begin
            n_result.status      = scfd_pkg::STATUS_OK;
            n_result.humidity    = r_humidity;
            // sign-magnitude to two's complement, minus zero folds to zero
            n_result.temperature = r_temperature[scfd_pkg::WORD_W-1] ? -w_magnitude
                                                                      : w_magnitude;
        end else begin
            n_result.status      = scfd_pkg::STATUS_BAD;
            n_result.humidity    = '0;
            n_result.temperature = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc         <= scfd_pkg::CRC_INIT;
            r_humidity    <= '0;
            r_temperature <= '0;
            r_crc_low     <= '0;
        end else if (w_fire) begin
            r_crc <= n_crc;
            case (i_item.pos)
                scfd_pkg::POS_HUM_HI:  r_humidity[15:8]    <= i_item.data;
                scfd_pkg::POS_HUM_LO:  r_humidity[7:0]     <= i_item.data;
                scfd_pkg::POS_TEMP_HI: r_temperature[15:8] <= i_item.data;
                scfd_pkg::POS_TEMP_LO: r_temperature[7:0]  <= i_item.data;
                scfd_pkg::POS_CRC_LO:  r_crc_low           <= i_item.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_last) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

@@ tb/sv/scfd_frame_checker.sv @@
// checker for the sensor frame decoder: predicts result words from accepted bytes and compares
`timescale 1ns / 1ps

module scfd_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,      // [7:0] rx_byte
    input  logic        i_in_start,     // [0] frame_start
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,     // [15:0] humidity_tenths, [31:16] temperature_tenths
    input  logic        i_out_status,   // [0] status
    output int          o_fail_count,
    output int          o_pending,
    output int          o_frames_checked,
    output int          o_bad_crc_frames
);

    // predicted decoder state
    logic [scfd_pkg::POS_W-1:0]  frame_pos;
    logic [scfd_pkg::WORD_W-1:0] crc_run;
    logic [scfd_pkg::WORD_W-1:0] hum_word;
    logic [scfd_pkg::WORD_W-1:0] temp_word;
    logic [scfd_pkg::BYTE_W-1:0] crc_lo;

    scfd_pkg::t_result expected_readings[$];
    scfd_pkg::t_result want;
    logic signed [scfd_pkg::WORD_W-1:0] got_temp;
    int fails;
    int checked;
    int bad_seen;

    function automatic logic [scfd_pkg::WORD_W-1:0] modbus_crc_step(
        input logic [scfd_pkg::WORD_W-1:0] acc,
        input logic [scfd_pkg::BYTE_W-1:0] b);
        logic [scfd_pkg::WORD_W-1:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ scfd_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic absorb_byte(input logic [scfd_pkg::BYTE_W-1:0] b, input logic start);
        logic [scfd_pkg::POS_W-1:0]  pos;
        logic [scfd_pkg::WORD_W-1:0] received;
        logic [scfd_pkg::WORD_W-1:0] mag;
        scfd_pkg::t_result           r;
        pos = start ? scfd_pkg::POS_FIRST : frame_pos;
        if (pos == scfd_pkg::POS_FIRST) begin
            crc_run = scfd_pkg::CRC_INIT;
        end
        if (pos < scfd_pkg::POS_CRC_LO) begin
            crc_run = modbus_crc_step(crc_run, b);
        end
        case (pos)
            scfd_pkg::POS_HUM_HI: hum_word[15:8] = b;
            scfd_pkg::POS_HUM_LO: hum_word[7:0] = b;
            scfd_pkg::POS_TEMP_HI: temp_word[15:8] = b;
            scfd_pkg::POS_TEMP_LO: temp_word[7:0] = b;
            scfd_pkg::POS_CRC_LO: crc_lo = b;
            scfd_pkg::POS_CRC_HI: begin
                received = {b, crc_lo};
                if (received == crc_run) begin
                    // sign-magnitude to two's complement, minus zero folds to zero
                    mag = {1'b0, temp_word[14:0]};
                    r.status = scfd_pkg::STATUS_OK;
                    r.humidity = hum_word;
                    r.temperature = temp_word[15] ? 16'(-mag) : mag;
                end else begin
                    r.status = scfd_pkg::STATUS_BAD;
                    r.humidity = '0;
                    r.temperature = '0;
                end
                expected_readings.push_back(r);
                crc_run = scfd_pkg::CRC_INIT;
            end
            default: ;
        endcase
        frame_pos = pos + 3'd1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos = scfd_pkg::POS_FIRST;
            crc_run = scfd_pkg::CRC_INIT;
            hum_word = '0;
            temp_word = '0;
            crc_lo = '0;
            expected_readings.delete();
            fails = 0;
            checked = 0;
            bad_seen = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                absorb_byte(i_in_data, i_in_start);
            end
            if (i_out_valid && i_out_ready) begin
                got_temp = i_out_data[31:16];
                if (expected_readings.size() == 0) begin
                    $error("result word with no frame waiting: status %0d humidity %0d temp %0d",
                           i_out_status, i_out_data[15:0], got_temp);
                    fails++;
                end else begin
                    want = expected_readings.pop_front();
                    checked++;
                    if (i_out_status == scfd_pkg::STATUS_BAD) begin
                        bad_seen++;
                    end
                    if (i_out_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_status);
                        fails++;
                    end
                    if (i_out_data[15:0] !== want.humidity) begin
                        $error("humidity_tenths: expected %0d, got %0d",
                               want.humidity, i_out_data[15:0]);
                        fails++;
                    end
                    if (got_temp !== want.temperature) begin
                        $error("temperature_tenths: expected %0d, got %0d",
                               want.temperature, got_temp);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_readings.size();
        o_frames_checked <= checked;
        o_bad_crc_frames <= bad_seen;
    end

endmodule

@@ tb/sv/sensor_frame_crc_decoder_unit_test.sv @@
// testbench top for the sensor frame decoder: clock, reset, byte stimulus, output stalls, verdict
`timescale 1ns / 1ps

module sensor_frame_crc_decoder_unit_test;

    localparam int RANDOM_BYTES = 1800;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} t_rx_pattern;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;    // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [15:0] humidity_tenths, [31:16] temperature_tenths
    logic        m_axis_tuser;           // [0] status

    int fail_count;
    int pending_readings;
    int frames_checked;
    int bad_crc_frames;

    int cycle_count = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int holds_served;
    int hold_left;
    int drains_done = 0;
    bit aligned = 1'b1;
    t_rx_pattern rx_mode;
    int rx_mode_left;

    sensor_frame_crc_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    scfd_frame_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .i_in_ready       (s_axis_tready),
        .i_in_data        (s_axis_tdata),
        .i_in_start       (s_axis_tuser),
        .i_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .i_out_data       (m_axis_tdata),
        .i_out_status     (m_axis_tuser),
        .o_fail_count     (fail_count),
        .o_pending        (pending_readings),
        .o_frames_checked (frames_checked),
        .o_bad_crc_frames (bad_crc_frames)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: changing stall patterns, plus long holds on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            holds_served <= 0;
            hold_left <= 0;
            rx_mode <= RX_OPEN;
            rx_mode_left <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= t_rx_pattern'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(10, 120);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN: m_axis_tready <= 1'b1;
                RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (cycle_count[1:0] != 2'd0);
            endcase
        end
    end

    // offers one word and waits for it; valid stays high into the next word unless a gap follows
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_reply(input logic [15:0] hum, input logic [15:0] temp,
                              input logic start, input bit corrupt);
        logic [7:0]  frame_bytes [8];
        logic [15:0] crc;
        int          idx;
        frame_bytes[0] = 8'($urandom_range(0, 255));
        frame_bytes[1] = 8'($urandom_range(0, 255));
        frame_bytes[2] = hum[15:8];
        frame_bytes[3] = hum[7:0];
        frame_bytes[4] = temp[15:8];
        frame_bytes[5] = temp[7:0];
        crc = scfd_pkg::CRC_INIT;
        for (idx = 0; idx < 6; idx++) begin
            crc = scfd_pkg::crc_feed(crc, frame_bytes[idx]);
        end
        frame_bytes[6] = crc[7:0];
        frame_bytes[7] = crc[15:8];
        // a single flipped bit anywhere always breaks the crc
        if (corrupt) begin
            idx = $urandom_range(0, 7);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
        for (idx = 0; idx < 8; idx++) begin
            send_byte(frame_bytes[idx], (idx == 0) ? start : 1'b0);
        end
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_readings != 0);
        repeat (4) @(posedge i_clk);
        drains_done++;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        int choice;
        int n;
        int k;
        int holds_issued;
        holds_issued = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, minus zero, a frame without start flag, resync mid frame, bad crc
        send_reply(16'hFFFF, 16'h7FFF, 1'b1, 1'b0);
        send_reply(16'h0000, 16'h8000, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_reply(16'h1234, 16'hFFFF, 1'b1, 1'b1);
        drain_replies();

        while (bytes_sent < RANDOM_BYTES) begin
            if (holds_issued < 2 && bytes_sent > 500 + 700 * holds_issued) begin
                hold_requests <= hold_requests + 1;
                holds_issued++;
            end
            if (drains_done < 3 && bytes_sent > 900 + 600 * (drains_done - 1)) begin
                drain_replies();
            end
            choice = $urandom_range(0, 99);
            if (choice < 65) begin
                send_reply(pick_word(), pick_word(), !aligned || $urandom_range(0, 1), 1'b0);
                aligned = 1'b1;
            end else if (choice < 80) begin
                send_reply(pick_word(), pick_word(), !aligned || $urandom_range(0, 1), 1'b1);
                aligned = 1'b1;
            end else if (choice < 90) begin
                n = $urandom_range(1, 9);
                for (k = 0; k < n; k++) begin
                    send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0));
                end
                aligned = 1'b0;
            end else begin
                // truncated frame, cut short by the next start
                n = $urandom_range(1, 7);
                for (k = 0; k < n; k++) begin
                    send_byte(8'($urandom_range(0, 255)), k == 0);
                end
                aligned = 1'b0;
            end
        end

        drain_replies();
        repeat (8) @(posedge i_clk);
        $display("drove %0d bytes across %0d long output holds and %0d full drains",
                 bytes_sent, holds_issued, drains_done);
        $display("compared %0d result words, %0d of them with a bad crc",
                 frames_checked, bad_crc_frames);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
